[design/tcw_pkg.sv]
package tcw_pkg;

    // Screen geometry and tab spacing.
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int TAB_STOP   = 8;
    localparam int CELL_COUNT = ROWS * COLUMNS;

    // Field widths.
    localparam int ADDR_W  = $clog2(CELL_COUNT);
    localparam int COL_W   = 7;
    localparam int ROW_W   = 5;
    localparam int CHAR_W  = 8;
    localparam int COLOR_W = 4;
    localparam int CELL_W  = 2 * CHAR_W;

    // Depth of the command queue between front and back.
    localparam int FIFO_DEPTH = 2;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_FOREGROUND = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BACKGROUND = 2'd1;

    localparam logic [COLOR_W-1:0] FG_RESET = 4'd7;
    localparam logic [COLOR_W-1:0] BG_RESET = 4'd0;

    // Operation codes of an input transaction.
    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Control characters.
    localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;
    localparam logic [CHAR_W-1:0] CH_BS  = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_VT  = 8'h0B;
    localparam logic [CHAR_W-1:0] CH_FF  = 8'h0C;
    localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;

    // Command classes produced by the front end.
    typedef logic [2:0] cls_t;
    localparam cls_t CLS_IGNORE   = 3'd0;
    localparam cls_t CLS_TAB      = 3'd1;
    localparam cls_t CLS_NEWLINE  = 3'd2;
    localparam cls_t CLS_FORMFEED = 3'd3;
    localparam cls_t CLS_RETURN   = 3'd4;
    localparam cls_t CLS_PRINT    = 3'd5;
    localparam cls_t CLS_READ     = 3'd6;

    typedef struct packed {
        cls_t              cls;
        logic [CHAR_W-1:0] ch;
        logic [ADDR_W-1:0] idx;
    } cmd_t;

    function automatic cls_t classify(logic op, logic [CHAR_W-1:0] ch);
        cls_t c;
        c = CLS_PRINT;
        if (op == OP_READ)
        begin
            c = CLS_READ;
        end
        else
        begin
            unique case (ch)
                CH_NUL, CH_BS: c = CLS_IGNORE;
                CH_TAB:        c = CLS_TAB;
                CH_LF, CH_VT:  c = CLS_NEWLINE;
                CH_FF:         c = CLS_FORMFEED;
                CH_CR:         c = CLS_RETURN;
                default:       c = CLS_PRINT;
            endcase
        end
        return c;
    endfunction

endpackage

[design/tcw_ram.sv]
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[design/tcw_front.sv]
module tcw_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic                          op,
    input  logic [tcw_pkg::CHAR_W-1:0]    char_code,
    input  logic [tcw_pkg::ADDR_W-1:0]    cell_index,
    output logic                          cmd_valid,
    output tcw_pkg::cmd_t                 cmd,
    input  logic                          cmd_take
);

    tcw_pkg::cmd_t                   slot_reg [tcw_pkg::FIFO_DEPTH];
    logic [tcw_pkg::PTR_W-1:0]       wr_ptr_reg;
    logic [tcw_pkg::PTR_W-1:0]       rd_ptr_reg;
    logic [tcw_pkg::CNT_W-1:0]       count_reg;
    logic [tcw_pkg::CNT_W-1:0]       count_next;
    logic                            accept;
    tcw_pkg::cmd_t                   new_cmd;

    assign full      = (count_reg == tcw_pkg::CNT_W'(tcw_pkg::FIFO_DEPTH));
    assign accept    = push && !full;
    assign cmd_valid = (count_reg != '0);
    assign cmd       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        new_cmd.cls = tcw_pkg::classify(op, char_code);
        new_cmd.ch  = char_code;
        new_cmd.idx = cell_index;
        count_next  = count_reg;
        if (accept && !cmd_take)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!accept && cmd_take)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            slot_reg[wr_ptr_reg] <= new_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (cmd_take)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

[design/tcw_back.sv]
module tcw_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cmd_valid,
    input  tcw_pkg::cmd_t                     cmd,
    output logic                              cmd_take,
    input  logic                              cfg_valid,
    input  logic [tcw_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [tcw_pkg::COLOR_W-1:0]       cfg_data,
    output logic                              empty,
    input  logic                              pop,
    output logic [tcw_pkg::CHAR_W-1:0]        cell_char,
    output logic [tcw_pkg::CHAR_W-1:0]        cell_attribute,
    output logic [tcw_pkg::COL_W-1:0]         cursor_column,
    output logic [tcw_pkg::ROW_W-1:0]         cursor_row,
    output logic                              scrolled
);

    localparam int AW = tcw_pkg::ADDR_W;
    localparam int CW = tcw_pkg::COL_W;
    localparam int RW = tcw_pkg::ROW_W;
    localparam int COPY_LAST = tcw_pkg::CELL_COUNT - tcw_pkg::COLUMNS;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_READ   = 3'd1;
    localparam logic [2:0] S_CLEAR  = 3'd2;
    localparam logic [2:0] S_SCROLL = 3'd3;
    localparam logic [2:0] S_BLANK  = 3'd4;
    localparam logic [2:0] S_PUTC   = 3'd5;

    logic [2:0]                        state_reg, state_next;
    logic [CW-1:0]                     col_reg, col_next;
    logic [RW-1:0]                     row_reg, row_next;
    logic [AW-1:0]                     sweep_reg, sweep_next;
    logic [tcw_pkg::COLOR_W-1:0]       fg_reg, bg_reg;
    logic [tcw_pkg::CELL_W-1:0]        pend_cell_reg, pend_cell_next;
    logic [AW-1:0]                     pend_addr_reg, pend_addr_next;
    logic                              out_valid_reg, out_valid_next;
    logic [tcw_pkg::CHAR_W-1:0]        out_char_reg, out_char_next;
    logic [tcw_pkg::CHAR_W-1:0]        out_attr_reg, out_attr_next;
    logic [CW-1:0]                     out_col_reg, out_col_next;
    logic [RW-1:0]                     out_row_reg, out_row_next;
    logic                              out_scr_reg, out_scr_next;
    logic                              in_range_reg, in_range_next;

    logic                              ram_we, ram_re;
    logic [AW-1:0]                     ram_waddr, ram_raddr;
    logic [tcw_pkg::CELL_W-1:0]        ram_wdata, ram_rdata;

    logic                              out_free;
    logic                              col_wrap;
    logic [CW-1:0]                     c1;
    logic [RW-1:0]                     row_inc, r1, r2;
    logic                              need_scroll;
    logic [CW:0]                       tab_col;
    logic [AW-1:0]                     put_addr;
    logic [tcw_pkg::CELL_W-1:0]        put_cell;

    tcw_ram #(
        .WIDTH (tcw_pkg::CELL_W),
        .DEPTH (tcw_pkg::CELL_COUNT)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign empty          = !out_valid_reg;
    assign cell_char      = out_char_reg;
    assign cell_attribute = out_attr_reg;
    assign cursor_column  = out_col_reg;
    assign cursor_row     = out_row_reg;
    assign scrolled       = out_scr_reg;

    always_comb
    begin
        out_free    = !out_valid_reg || pop;
        cmd_take    = (state_reg == S_IDLE) && cmd_valid && out_free;
        col_wrap    = (col_reg >= CW'(tcw_pkg::COLUMNS));
        row_inc     = (row_reg < RW'(tcw_pkg::ROWS)) ? row_reg + 1'b1 : row_reg;
        c1          = col_wrap ? '0 : col_reg;
        r1          = col_wrap ? row_inc : row_reg;
        need_scroll = (r1 >= RW'(tcw_pkg::ROWS));
        r2          = need_scroll ? RW'(tcw_pkg::ROWS - 1) : r1;
        tab_col     = {1'b0, col_reg} + (CW + 1)'(tcw_pkg::TAB_STOP);
        put_addr    = AW'(r2) * AW'(tcw_pkg::COLUMNS) + AW'(c1);
        put_cell    = {bg_reg, fg_reg, cmd.ch};

        state_next     = state_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        sweep_next     = sweep_reg;
        pend_cell_next = pend_cell_reg;
        pend_addr_next = pend_addr_reg;
        in_range_next  = in_range_reg;
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_attr_next  = out_attr_reg;
        out_col_next   = out_col_reg;
        out_row_next   = out_row_reg;
        out_scr_next   = out_scr_reg;
        ram_we         = 1'b0;
        ram_waddr      = sweep_reg;
        ram_wdata      = '0;
        ram_re         = 1'b0;
        ram_raddr      = cmd.idx;

        if (pop)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_take)
                begin
                    case (cmd.cls)
                        tcw_pkg::CLS_TAB:
                        begin
                            if (tab_col >= (CW + 1)'(tcw_pkg::COLUMNS - tcw_pkg::TAB_STOP))
                            begin
                                col_next = '0;
                                row_next = row_inc;
                            end
                            else
                            begin
                                col_next = tab_col[CW-1:0];
                            end
                        end
                        tcw_pkg::CLS_NEWLINE:
                        begin
                            col_next = '0;
                            row_next = row_inc;
                        end
                        tcw_pkg::CLS_RETURN:
                        begin
                            col_next = '0;
                        end
                        tcw_pkg::CLS_FORMFEED:
                        begin
                            col_next   = '0;
                            row_next   = '0;
                            sweep_next = '0;
                            state_next = S_CLEAR;
                        end
                        tcw_pkg::CLS_PRINT:
                        begin
                            col_next = c1 + 1'b1;
                            row_next = r2;
                            if (need_scroll)
                            begin
                                pend_cell_next = put_cell;
                                pend_addr_next = put_addr;
                                sweep_next     = '0;
                                state_next     = S_SCROLL;
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = put_addr;
                                ram_wdata = put_cell;
                            end
                        end
                        tcw_pkg::CLS_READ:
                        begin
                            in_range_next = (cmd.idx < AW'(tcw_pkg::CELL_COUNT));
                            ram_re        = in_range_next;
                            state_next    = S_READ;
                        end
                        default:
                        begin
                        end
                    endcase

                    if (cmd.cls != tcw_pkg::CLS_READ)
                    begin
                        out_valid_next = 1'b1;
                        out_char_next  = '0;
                        out_attr_next  = '0;
                        out_col_next   = col_next;
                        out_row_next   = row_next;
                        out_scr_next   = (cmd.cls == tcw_pkg::CLS_PRINT) && need_scroll;
                    end
                end
            end
            S_READ:
            begin
                out_valid_next = 1'b1;
                out_char_next  = in_range_reg ? ram_rdata[tcw_pkg::CHAR_W-1:0] : '0;
                out_attr_next  = in_range_reg ? ram_rdata[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W]
                                              : '0;
                out_col_next   = col_reg;
                out_row_next   = row_reg;
                out_scr_next   = 1'b0;
                state_next     = S_IDLE;
            end
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = sweep_reg;
                if (sweep_reg == AW'(tcw_pkg::CELL_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end
            S_SCROLL:
            begin
                // Read one row below, write the word fetched last cycle.
                ram_re    = (sweep_reg < AW'(COPY_LAST));
                ram_raddr = sweep_reg + AW'(tcw_pkg::COLUMNS);
                ram_we    = (sweep_reg != '0);
                ram_waddr = sweep_reg - 1'b1;
                ram_wdata = ram_rdata;
                if (sweep_reg == AW'(COPY_LAST))
                begin
                    state_next = S_BLANK;
                end
                else
                begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end
            S_BLANK:
            begin
                ram_we    = 1'b1;
                ram_waddr = sweep_reg;
                if (sweep_reg == AW'(tcw_pkg::CELL_COUNT - 1))
                begin
                    state_next = S_PUTC;
                end
                else
                begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end
            S_PUTC:
            begin
                ram_we     = 1'b1;
                ram_waddr  = pend_addr_reg;
                ram_wdata  = pend_cell_reg;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        pend_cell_reg <= pend_cell_next;
        pend_addr_reg <= pend_addr_next;
        in_range_reg  <= in_range_next;
        out_char_reg  <= out_char_next;
        out_attr_reg  <= out_attr_next;
        out_col_reg   <= out_col_next;
        out_row_reg   <= out_row_next;
        out_scr_reg   <= out_scr_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            sweep_reg     <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
            fg_reg        <= tcw_pkg::FG_RESET;
            bg_reg        <= tcw_pkg::BG_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && (cfg_index == tcw_pkg::CFG_FOREGROUND))
            begin
                fg_reg <= cfg_data;
            end
            if (cfg_valid && (cfg_index == tcw_pkg::CFG_BACKGROUND))
            begin
                bg_reg <= cfg_data;
            end
        end
    end

endmodule

[design/text_console_writer_core.sv]
// Channel   Handshake                 Payload
// -------   -----------------------   ------------------------------------------------
// input     push / full               op, char_code, cell_index
// result    empty / pop               cell_char, cell_attribute, cursor_column,
//                                     cursor_row, scrolled
// config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// A plain character or a cursor control code goes from the queue head straight
// into the result registers; a read first passes the RAM read and S_READ. A
// scroll keeps the back end busy while it moves 1920 cells through the single
// cell RAM port pair; a form feed clears the RAM after the cycle that takes it.
// After reset the back end runs a clearing pass over the cell RAM before it
// takes the first transaction; inputs still queue in the front end.
// The front end queues two transactions, so input and result stall independently.
module text_console_writer_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic                                 op,
    input  logic [tcw_pkg::CHAR_W-1:0]           char_code,
    input  logic [tcw_pkg::ADDR_W-1:0]           cell_index,
    output logic                                 empty,
    input  logic                                 pop,
    output logic [tcw_pkg::CHAR_W-1:0]           cell_char,
    output logic [tcw_pkg::CHAR_W-1:0]           cell_attribute,
    output logic [tcw_pkg::COL_W-1:0]            cursor_column,
    output logic [tcw_pkg::ROW_W-1:0]            cursor_row,
    output logic                                 scrolled,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [tcw_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [tcw_pkg::COLOR_W-1:0]          cfg_data
);

    // Command path from the classifying front end to the executing back end.
    logic          cmd_valid;
    logic          cmd_take;
    tcw_pkg::cmd_t cmd;

    // Color registers may be written at any time the block is idle.
    assign cfg_ready = 1'b1;

    tcw_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .op         (op),
        .char_code  (char_code),
        .cell_index (cell_index),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_take   (cmd_take)
    );

    tcw_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (cmd_valid),
        .cmd            (cmd),
        .cmd_take       (cmd_take),
        .cfg_valid      (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .empty          (empty),
        .pop            (pop),
        .cell_char      (cell_char),
        .cell_attribute (cell_attribute),
        .cursor_column  (cursor_column),
        .cursor_row     (cursor_row),
        .scrolled       (scrolled)
    );

endmodule

[design/tcw_checker.sv]
module tcw_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        empty,
    input logic                        pop,
    input logic [tcw_pkg::CHAR_W-1:0]  cell_char,
    input logic [tcw_pkg::COL_W-1:0]   cursor_column,
    input logic [tcw_pkg::ROW_W-1:0]   cursor_row,
    input logic                        scrolled
);

    a_reset_empty: assert property (@(posedge clk) !rst_n |-> empty)
        else $error("result queue not empty during reset");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(cell_char) && $stable(cursor_column)))
        else $error("waiting result changed");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (cursor_column <= tcw_pkg::COL_W'(tcw_pkg::COLUMNS)
                    && cursor_row <= tcw_pkg::ROW_W'(tcw_pkg::ROWS)))
        else $error("cursor out of range");

    // A scrolling character always lands on the bottom row.
    a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && scrolled) |-> (cursor_row == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1)
                                  && cell_char == '0))
        else $error("scroll result has wrong cursor");

endmodule

bind text_console_writer_core tcw_checker u_tcw_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .empty         (empty),
    .pop           (pop),
    .cell_char     (cell_char),
    .cursor_column (cursor_column),
    .cursor_row    (cursor_row),
    .scrolled      (scrolled)
);

[test/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
    import tcw_pkg::*;

    // One result transaction as the console reports it.
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic [CHAR_W-1:0] attr;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic              scr;
    } console_result_t;

    // One row of the directed stimulus table. When has_known is set, the
    // expected result is typed in; otherwise the console model supplies it.
    typedef struct {
        logic              op;
        logic [CHAR_W-1:0] ch;
        logic [ADDR_W-1:0] idx;
        bit                has_known;
        console_result_t   known;
    } directed_row_t;

    localparam int LIMIT_CYCLES = 12000000;
    localparam int DRAIN_CYCLES = 4200;
    localparam int HOLD_CYCLES  = 400;

    logic                clk;
    logic                rst_n;
    logic                push;
    logic                full;
    logic                op;
    logic [CHAR_W-1:0]   char_code;
    logic [ADDR_W-1:0]   cell_index;
    logic                empty;
    logic                pop;
    logic [CHAR_W-1:0]   cell_char;
    logic [CHAR_W-1:0]   cell_attribute;
    logic [COL_W-1:0]    cursor_column;
    logic [ROW_W-1:0]    cursor_row;
    logic                scrolled;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [COLOR_W-1:0]  cfg_data;

    // Console model: its own copy of the screen, the cursor and the colors.
    logic [CELL_W-1:0]   screen [CELL_COUNT];
    int unsigned         cur_col;
    int unsigned         cur_row;
    logic [COLOR_W-1:0]  fg_color;
    logic [COLOR_W-1:0]  bg_color;

    // Results that the console still owes, oldest first.
    console_result_t     pending_results [$];

    int                  send_idle_pct;
    int                  recv_idle_pct;
    bit                  hold_request;
    int                  hold_left;
    int                  error_count;
    int unsigned         cycle_count;

    text_console_writer_core u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .op             (op),
        .char_code      (char_code),
        .cell_index     (cell_index),
        .empty          (empty),
        .pop            (pop),
        .cell_char      (cell_char),
        .cell_attribute (cell_attribute),
        .cursor_column  (cursor_column),
        .cursor_row     (cursor_row),
        .scrolled       (scrolled),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // Moving down a row parks the cursor in column zero. The row stops one
    // past the bottom; the scroll waits for the next printable byte.
    function automatic void console_new_line();
        cur_col = 0;
        if (cur_row < ROWS)
        begin
            cur_row++;
        end
    endfunction

    // Applies one accepted input transaction to the console model and returns
    // the result that the block has to produce for it.
    function automatic console_result_t console_apply(logic o, logic [CHAR_W-1:0] c,
                                                      logic [ADDR_W-1:0] idx);
        console_result_t r;
        r = '0;
        if (o == OP_READ)
        begin
            if (idx < CELL_COUNT)
            begin
                r.ch   = screen[idx][CHAR_W-1:0];
                r.attr = screen[idx][CELL_W-1:CHAR_W];
            end
        end
        else
        begin
            case (c)
                CH_NUL, CH_BS:
                begin
                end
                CH_TAB:
                begin
                    cur_col += TAB_STOP;
                    if (cur_col >= COLUMNS - TAB_STOP)
                    begin
                        console_new_line();
                    end
                end
                CH_LF, CH_VT:
                begin
                    console_new_line();
                end
                CH_FF:
                begin
                    foreach (screen[i])
                    begin
                        screen[i] = '0;
                    end
                    cur_col = 0;
                    cur_row = 0;
                end
                CH_CR:
                begin
                    cur_col = 0;
                end
                default:
                begin
                    if (cur_col >= COLUMNS)
                    begin
                        console_new_line();
                    end
                    if (cur_row >= ROWS)
                    begin
                        // Everything moves up a row and the bottom row goes blank.
                        for (int i = 0; i < CELL_COUNT - COLUMNS; i++)
                        begin
                            screen[i] = screen[i + COLUMNS];
                        end
                        for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
                        begin
                            screen[i] = '0;
                        end
                        cur_row = ROWS - 1;
                        r.scr   = 1'b1;
                    end
                    screen[cur_row * COLUMNS + cur_col] = {bg_color, fg_color, c};
                    cur_col++;
                end
            endcase
        end
        r.col = cur_col[COL_W-1:0];
        r.row = cur_row[ROW_W-1:0];
        return r;
    endfunction

    // Offers one input transaction, holding it until the block takes it. The
    // sender's random gaps are inserted before the item, and push is lowered
    // only inside such a gap so that it never drops and rises in one step.
    task automatic send_item(logic o, logic [CHAR_W-1:0] c, logic [ADDR_W-1:0] idx,
                             bit has_known, console_result_t known);
        console_result_t r;
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push       <= 1'b1;
        op         <= o;
        char_code  <= c;
        cell_index <= idx;
        do
        begin
            @(posedge clk);
        end
        while (full);
        r = console_apply(o, c, idx);
        // A typed-in expectation is checked against the model as well, so a
        // slip in either one shows up.
        if (has_known && r != known)
        begin
            $display("%0t: table row disagrees with model: expected %h, model %h",
                     $time, known, r);
            error_count++;
        end
        pending_results.push_back(has_known ? known : r);
    endtask

    // Waits for every owed result, then lets the back end settle before a
    // register write, since a form feed or scroll keeps it busy for a while.
    task automatic wait_until_drained();
        push <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_color(logic [CFG_INDEX_W-1:0] index, logic [COLOR_W-1:0] value);
        wait_until_drained();
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (index == CFG_FOREGROUND)
        begin
            fg_color = value;
        end
        else
        begin
            bg_color = value;
        end
    endtask

    // Random traffic is mostly printable text broken by line controls, so
    // the cursor runs down the screen and the screen scrolls now and then.
    // Half of the reads look near the cursor where text has just been written.
    task automatic send_random(int count);
        int                kind;
        logic [CHAR_W-1:0] c;
        logic [ADDR_W-1:0] idx;
        for (int n = 0; n < count; n++)
        begin
            kind = $urandom_range(99);
            c    = '0;
            idx  = '0;
            if (kind < 28)
            begin
                if ($urandom_range(1) == 0)
                begin
                    idx = ADDR_W'($urandom_range((1 << ADDR_W) - 1));
                end
                else
                begin
                    idx = ADDR_W'(((cur_row >= ROWS) ? ROWS - 1 : cur_row) * COLUMNS
                                  + $urandom_range(COLUMNS - 1));
                end
                send_item(OP_READ, CHAR_W'($urandom_range(255)), idx, 1'b0, '0);
            end
            else
            begin
                if (kind < 34)
                begin
                    c = ($urandom_range(1) == 0) ? CH_LF : CH_VT;
                end
                else if (kind < 37)
                begin
                    c = CH_TAB;
                end
                else if (kind < 39)
                begin
                    c = CH_CR;
                end
                else if (kind < 40)
                begin
                    c = ($urandom_range(1) == 0) ? CH_NUL : CH_BS;
                end
                else if (kind == 40 && $urandom_range(3) == 0)
                begin
                    c = CH_FF;
                end
                else
                begin
                    do
                    begin
                        c = CHAR_W'($urandom_range(255));
                    end
                    while (c == CH_NUL || (c >= CH_BS && c <= CH_CR));
                end
                send_item(OP_PUT, c, ADDR_W'($urandom_range((1 << ADDR_W) - 1)),
                          1'b0, '0);
            end
        end
    endtask

    // The receiver pops at random, except while a long hold is in force.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop       <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_request && hold_left == 0)
        begin
            pop       <= 1'b0;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left > 0)
        begin
            pop       <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
        begin
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Every accepted result transaction is compared with the oldest owed one.
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result: got %h %h %0d %0d %b", $time,
                         cell_char, cell_attribute, cursor_column, cursor_row, scrolled);
                error_count++;
            end
            else
            begin
                console_result_t want;
                want = pending_results.pop_front();
                if (cell_char !== want.ch)
                begin
                    $display("%0t: cell_char expected %h got %h", $time, want.ch, cell_char);
                    error_count++;
                end
                if (cell_attribute !== want.attr)
                begin
                    $display("%0t: cell_attribute expected %h got %h", $time,
                             want.attr, cell_attribute);
                    error_count++;
                end
                if (cursor_column !== want.col)
                begin
                    $display("%0t: cursor_column expected %0d got %0d", $time,
                             want.col, cursor_column);
                    error_count++;
                end
                if (cursor_row !== want.row)
                begin
                    $display("%0t: cursor_row expected %0d got %0d", $time,
                             want.row, cursor_row);
                    error_count++;
                end
                if (scrolled !== want.scr)
                begin
                    $display("%0t: scrolled expected %b got %b", $time, want.scr, scrolled);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: a run that hangs ends here as a failure. The counter starts
    // at zero as every int unsigned does.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        directed_row_t table_rows [$];
        directed_row_t row;

        rst_n         = 1'b0;
        push          = 1'b0;
        op            = OP_PUT;
        char_code     = '0;
        cell_index    = '0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_FOREGROUND;
        cfg_data      = '0;
        hold_request  = 1'b0;
        error_count   = 0;
        send_idle_pct = 22;
        recv_idle_pct = 82;
        foreach (screen[i])
        begin
            screen[i] = '0;
        end
        cur_col  = 0;
        cur_row  = 0;
        fg_color = FG_RESET;
        bg_color = BG_RESET;

        // Directed table: the screen is blank after reset, out-of-range reads
        // give zero, and a form feed homes the cursor. Rows without a typed-in
        // value cover all control codes but form feed and the printable edges.
        table_rows = '{
            '{OP_READ, 8'h00, 11'd0,    1'b1, '{8'h00, 8'h00, 7'd0, 5'd0, 1'b0}},
            '{OP_READ, 8'hFF, 11'd2047, 1'b1, '{8'h00, 8'h00, 7'd0, 5'd0, 1'b0}},
            '{OP_READ, 8'h00, 11'd1999, 1'b1, '{8'h00, 8'h00, 7'd0, 5'd0, 1'b0}},
            '{OP_PUT,  8'h41, 11'd0,    1'b1, '{8'h00, 8'h00, 7'd1, 5'd0, 1'b0}},
            '{OP_PUT,  CH_NUL, 11'd0,   1'b0, '0},
            '{OP_PUT,  CH_BS,  11'h7FF, 1'b0, '0},
            '{OP_PUT,  8'h7F, 11'd0,    1'b0, '0},
            '{OP_PUT,  8'h80, 11'd0,    1'b0, '0},
            '{OP_PUT,  8'hFF, 11'd0,    1'b0, '0},
            '{OP_PUT,  8'h01, 11'd0,    1'b0, '0},
            '{OP_PUT,  CH_TAB, 11'd0,   1'b0, '0},
            '{OP_PUT,  CH_CR,  11'd0,   1'b0, '0},
            '{OP_PUT,  CH_LF,  11'd0,   1'b0, '0},
            '{OP_PUT,  CH_VT,  11'd0,   1'b0, '0},
            '{OP_PUT,  8'h20, 11'd0,    1'b0, '0},
            '{OP_READ, 8'h00, 11'd0,    1'b0, '0},
            '{OP_READ, 8'h00, 11'd3,    1'b0, '0},
            '{OP_READ, 8'h00, 11'd160,  1'b0, '0},
            '{OP_READ, 8'h00, 11'd2000, 1'b0, '0},
            '{OP_PUT,  CH_FF,  11'd0,   1'b1, '{8'h00, 8'h00, 7'd0, 5'd0, 1'b0}},
            '{OP_READ, 8'h00, 11'd0,    1'b1, '{8'h00, 8'h00, 7'd0, 5'd0, 1'b0}}
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (table_rows[i])
        begin
            row = table_rows[i];
            send_item(row.op, row.ch, row.idx, row.has_known, row.known);
        end

        // Tabs walk across a row until the near-edge wrap, then newlines run
        // the cursor off the bottom so the next character scrolls the screen.
        for (int i = 0; i < 10; i++)
        begin
            send_item(OP_PUT, CH_TAB, '0, 1'b0, '0);
        end
        for (int i = 0; i < ROWS + 1; i++)
        begin
            send_item(OP_PUT, CH_LF, '0, 1'b0, '0);
        end
        send_item(OP_PUT, 8'h5A, '0, 1'b0, '0);
        send_item(OP_READ, '0, ADDR_W'(CELL_COUNT - COLUMNS), 1'b0, '0);

        // Phase one: reset colors, sender mostly busy, receiver mostly stalled.
        send_random(300);

        // The sender stops until the console has answered everything.
        push <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end

        write_color(CFG_FOREGROUND, 4'd15);
        write_color(CFG_BACKGROUND, 4'd15);
        send_idle_pct = 82;
        recv_idle_pct = 22;

        // Phase two: the receiver holds off for a long stretch while the
        // sender keeps offering, so the input side backs up.
        hold_request = 1'b1;
        @(posedge clk);
        hold_request = 1'b0;
        send_random(300);

        write_color(CFG_FOREGROUND, 4'd0);
        write_color(CFG_BACKGROUND, 4'd9);
        send_idle_pct = 0;
        recv_idle_pct = 0;

        // Phase three: full rate on both sides.
        send_random(300);

        wait_until_drained();
        if (error_count == 0 && pending_results.size() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
